// ----- hw/rtl/imf_pkg.sv -----
// Package with the shared types and constants of the incremental max-flow unit.
package imf_pkg;

    localparam int VTX_W  = 9;
    localparam int CAP_W  = 16;
    localparam int FLOW_W = 28;
    localparam int CIDX_W = 2;

    localparam logic REQ_CLEAR = 1'b0;
    localparam logic REQ_ADD   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_VCOUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SOURCE = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_SINK   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_LK0, S_LK1, S_LK2, S_LK3, S_LK4, S_LK5,
        S_IN_RD, S_IN_WR, S_CHK, S_SC_LD, S_SC_A, S_SC_B, S_SC_C,
        S_RT_A, S_RT_B, S_RL_F, S_RL_F2, S_RL_A, S_RL_B, S_RL_C,
        S_RL_END, S_RL_INC, S_RL_P, S_RL_T,
        S_AG_P, S_AG_Q, S_AG_R, S_AG_S, S_DONE
    } t_state;

endpackage

// ----- hw/rtl/imf_if.sv -----
// Channel interfaces for requests, responses and configuration writes.
interface imf_req_if import imf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [VTX_W-1:0] first_vertex;
    logic [VTX_W-1:0] second_vertex;
    logic [CAP_W-1:0] edge_capacity;
    modport source (output valid, req_type, first_vertex, second_vertex, edge_capacity,
                    input ready);
    modport sink   (input valid, req_type, first_vertex, second_vertex, edge_capacity,
                    output ready);
endinterface

interface imf_rsp_if import imf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FLOW_W-1:0] added_flow;
    logic [1:0]        status;
    modport source (output valid, added_flow, status, input ready);
    modport sink   (input valid, added_flow, status, output ready);
endinterface

interface imf_cfg_if import imf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [VTX_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/incremental_max_flow_isap_unit.sv -----
// Incremental max-flow unit: arc and vertex memories driven by an ISAP sequencer.
//
// Channels: i_req carries one request word (clear graph, or add an undirected
// edge and augment); o_rsp returns one word per request with the flow gained
// and a status; i_cfg writes vertex_count, source_vertex and sink_vertex and
// is always ready. The user must write configuration only while the unit is
// idle; the unit itself does not enforce this. A clear or refused request
// goes straight to the final state. An add request links four arcs, resets
// the labels and current arcs of every vertex, then searches: it scans arcs,
// finds the bottleneck along each path to the sink, pushes it along that
// path, and relabels a vertex whose arcs are used up. All work runs through
// the single read port of the arc memory, which sets the pace.
// One request is in flight at a time; the next is accepted once its result
// sits in the output register, even while the receiver stalls. A second
// result waits in the final state until the output register is free.
// Reset empties every adjacency list (per-vertex valid bits), zeroes the arc
// count and loads the register defaults; arc memories need no clearing.
module incremental_max_flow_isap_unit
    import imf_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_ARCS     = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    imf_req_if.sink   i_req,
    imf_rsp_if.source o_rsp,
    imf_cfg_if.sink   i_cfg
);

    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_ARCS);
    localparam int PW = $clog2(MAX_ARCS + 1);
    localparam int CW = (VW > VTX_W) ? VW + 1 : VTX_W + 1;
    localparam logic [PW-1:0] EMPTY = PW'(MAX_ARCS);

    // Arc memories, one shared read address.
    logic [VW-1:0]    mem_tail [MAX_ARCS];
    logic [VW-1:0]    mem_head [MAX_ARCS];
    logic [PW-1:0]    mem_next [MAX_ARCS];
    logic [CAP_W-1:0] mem_res  [MAX_ARCS];
    // Vertex memories.
    logic [PW-1:0]    mem_fa   [MAX_VERTICES + 1];
    logic             r_fa_vld [MAX_VERTICES + 1];
    logic [VW-1:0]    mem_dist [MAX_VERTICES + 1];
    logic [VW-1:0]    mem_cnt  [MAX_VERTICES + 1];
    logic [PW-1:0]    mem_cur  [MAX_VERTICES + 1];
    logic [AW-1:0]    mem_par  [MAX_VERTICES + 1];

    logic [AW-1:0] arc_ra, arc_wa, res_wa;
    logic          arc_we, res_we;
    logic [VW-1:0] arc_wtail, arc_whead;
    logic [PW-1:0] arc_wnext;
    logic [CAP_W-1:0] res_wd;
    logic [VW-1:0] arc_rd_tail, arc_rd_head;
    logic [PW-1:0] arc_rd_next;
    logic [CAP_W-1:0] arc_rd_res;

    logic [VW-1:0] fa_ra, fa_wa;
    logic          fa_we, fa_clr;
    logic [PW-1:0] fa_wd, fa_rd, fa_cur;
    logic          fa_rv;
    logic [VW-1:0] dist_ra, dist_wa, dist_wd, dist_rd;
    logic          dist_we;
    logic [VW-1:0] cnt_ra, cnt_wa, cnt_wd, cnt_rd;
    logic          cnt_we;
    logic [VW-1:0] cur_ra, cur_wa;
    logic          cur_we;
    logic [PW-1:0] cur_wd, cur_rd;
    logic [VW-1:0] par_ra, par_wa;
    logic          par_we;
    logic [AW-1:0] par_wd, par_rd;

    t_state            r_state, n_state;
    logic [VTX_W-1:0]  r_vcount, r_src, r_snk;
    logic [VW-1:0]     r_x, n_x, r_y, n_y, r_i, n_i, r_v, n_v;
    logic [CAP_W-1:0]  r_c, n_c, r_nf, n_nf, r_res, n_res;
    logic [PW-1:0]     r_k, n_k, r_a, n_a, r_fa, n_fa, r_next, n_next;
    logic [VW-1:0]     r_di, n_di, r_dsrc, n_dsrc, r_newd, n_newd, r_head, n_head;
    logic [AW-1:0]     r_p, n_p;
    logic              r_pass, n_pass;
    logic [FLOW_W-1:0] r_total, n_total;
    logic [1:0]        r_stat, n_stat;
    logic              r_ov;
    logic [FLOW_W-1:0] r_oflow;
    logic [1:0]        r_ostat;

    logic              load_out, cfg_bad, vtx_bad, arc_usable;
    logic [CW-1:0]     n_ext, head_ext, dist_p1;
    logic [PW:0]       k_plus4;

    // Arc memories.
    always_ff @(posedge i_clk) begin
        if (arc_we) begin
            mem_tail[arc_wa] <= arc_wtail;
            mem_head[arc_wa] <= arc_whead;
            mem_next[arc_wa] <= arc_wnext;
        end
        if (res_we) begin
            mem_res[res_wa] <= res_wd;
        end
        arc_rd_tail <= mem_tail[arc_ra];
        arc_rd_head <= mem_head[arc_ra];
        arc_rd_next <= mem_next[arc_ra];
        arc_rd_res  <= mem_res[arc_ra];
    end

    // Vertex memories.
    always_ff @(posedge i_clk) begin
        if (fa_we)   mem_fa[fa_wa] <= fa_wd;
        if (dist_we) mem_dist[dist_wa] <= dist_wd;
        if (cnt_we)  mem_cnt[cnt_wa] <= cnt_wd;
        if (cur_we)  mem_cur[cur_wa] <= cur_wd;
        if (par_we)  mem_par[par_wa] <= par_wd;
        fa_rd   <= mem_fa[fa_ra];
        fa_rv   <= r_fa_vld[fa_ra];
        dist_rd <= mem_dist[dist_ra];
        cnt_rd  <= mem_cnt[cnt_ra];
        cur_rd  <= mem_cur[cur_ra];
        par_rd  <= mem_par[par_ra];
    end

    // An adjacency head that was never written since the last clear is empty.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= MAX_VERTICES; j++) begin
            if (!i_rst_n || fa_clr) begin
                r_fa_vld[j] <= 1'b0;
            end else if (fa_we && fa_wa == VW'(j)) begin
                r_fa_vld[j] <= 1'b1;
            end
        end
    end

    assign fa_cur = fa_rv ? fa_rd : EMPTY;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VTX_W'(2);
            r_src    <= VTX_W'(1);
            r_snk    <= VTX_W'(2);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_VCOUNT: r_vcount <= i_cfg.data;
                CFG_SOURCE: r_src    <= i_cfg.data;
                CFG_SINK:   r_snk    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign n_ext = CW'(r_vcount);
    assign cfg_bad = (r_vcount < VTX_W'(2)) || (n_ext > CW'(MAX_VERTICES))
                   || (r_src == '0) || (r_src > r_vcount)
                   || (r_snk == '0) || (r_snk > r_vcount) || (r_src == r_snk);
    assign vtx_bad = (i_req.first_vertex == '0) || (i_req.first_vertex > r_vcount)
                   || (i_req.second_vertex == '0) || (i_req.second_vertex > r_vcount);
    assign k_plus4 = {1'b0, r_k} + (PW + 1)'(4);

    assign head_ext   = CW'(r_head);
    assign dist_p1    = CW'(dist_rd) + CW'(1);
    assign arc_usable = (r_res != '0) && (head_ext <= n_ext);

    assign i_req.ready = (r_state == S_IDLE);
    assign load_out    = (r_state == S_DONE) && (!r_ov || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_c <= n_c; r_i <= n_i; r_v <= n_v;
        r_nf <= n_nf; r_res <= n_res; r_a <= n_a; r_fa <= n_fa;
        r_next <= n_next; r_di <= n_di; r_dsrc <= n_dsrc; r_newd <= n_newd;
        r_head <= n_head; r_p <= n_p; r_pass <= n_pass; r_total <= n_total;
        r_stat <= n_stat;
        if (load_out) begin
            r_oflow <= r_total;
            r_ostat <= r_stat;
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.added_flow = r_oflow;
    assign o_rsp.status     = r_ostat;

    always_comb begin
        n_state = r_state;
        n_x = r_x; n_y = r_y; n_c = r_c; n_i = r_i; n_v = r_v;
        n_nf = r_nf; n_res = r_res; n_a = r_a; n_fa = r_fa; n_next = r_next;
        n_di = r_di; n_dsrc = r_dsrc; n_newd = r_newd; n_head = r_head;
        n_p = r_p; n_pass = r_pass; n_total = r_total; n_stat = r_stat; n_k = r_k;
        arc_ra = r_a[AW-1:0]; arc_we = 1'b0; arc_wa = r_k[AW-1:0];
        arc_wtail = r_x; arc_whead = r_y; arc_wnext = EMPTY;
        res_we = 1'b0; res_wa = r_k[AW-1:0]; res_wd = r_c;
        fa_ra = r_x; fa_we = 1'b0; fa_wa = r_x; fa_wd = r_k; fa_clr = 1'b0;
        dist_ra = r_i; dist_we = 1'b0; dist_wa = r_v; dist_wd = '0;
        cnt_ra = r_di; cnt_we = 1'b0; cnt_wa = r_v; cnt_wd = '0;
        cur_ra = r_i; cur_we = 1'b0; cur_wa = r_i; cur_wd = EMPTY;
        par_ra = r_i; par_we = 1'b0; par_wa = r_head; par_wd = r_a[AW-1:0];
        case (r_state)
            S_IDLE: begin
                n_total = '0;
                if (i_req.valid) begin
                    n_state = S_DONE;
                    n_stat  = ST_OK;
                    if (i_req.req_type == REQ_CLEAR) begin
                        fa_clr = 1'b1;
                        n_k    = '0;
                    end else if (cfg_bad || vtx_bad) begin
                        n_stat = ST_RANGE;
                    end else if (k_plus4 > (PW + 1)'(MAX_ARCS)) begin
                        n_stat = ST_FULL;
                    end else begin
                        n_x = VW'(i_req.first_vertex);
                        n_y = VW'(i_req.second_vertex);
                        n_c = i_req.edge_capacity;
                        n_state = S_LK0;
                    end
                end
            end
            S_LK0: begin
                fa_ra   = r_x;
                n_state = S_LK1;
            end
            S_LK1: begin
                arc_we = 1'b1; arc_wnext = fa_cur; res_we = 1'b1;
                fa_we  = 1'b1;
                n_state = S_LK2;
            end
            S_LK2: begin
                fa_ra   = r_y;
                n_state = S_LK3;
            end
            S_LK3: begin
                arc_we = 1'b1; arc_wa = r_k[AW-1:0] + AW'(1);
                arc_wtail = r_y; arc_whead = r_x; arc_wnext = fa_cur;
                res_we = 1'b1; res_wa = arc_wa; res_wd = '0;
                n_state = S_LK4;
            end
            S_LK4: begin
                arc_we = 1'b1; arc_wa = r_k[AW-1:0] + AW'(2);
                arc_wtail = r_y; arc_whead = r_x; arc_wnext = r_k + PW'(1);
                res_we = 1'b1; res_wa = arc_wa;
                fa_we = 1'b1; fa_wa = r_y; fa_wd = r_k + PW'(2);
                n_state = S_LK5;
            end
            S_LK5: begin
                // With a self loop the list head is the arc linked in S_LK4.
                arc_we = 1'b1; arc_wa = r_k[AW-1:0] + AW'(3);
                arc_wnext = (r_x == r_y) ? r_k + PW'(2) : r_k;
                res_we = 1'b1; res_wa = arc_wa; res_wd = '0;
                fa_we = 1'b1; fa_wd = r_k + PW'(3);
                n_k = k_plus4[PW-1:0];
                cnt_we = 1'b1; cnt_wa = '0; cnt_wd = VW'(r_vcount);
                n_v = VW'(1);
                n_state = S_IN_RD;
            end
            S_IN_RD: begin
                fa_ra   = r_v;
                n_state = S_IN_WR;
            end
            S_IN_WR: begin
                dist_we = 1'b1; cnt_we = 1'b1;
                cur_we = 1'b1; cur_wa = r_v; cur_wd = fa_cur;
                if (CW'(r_v) == n_ext) begin
                    n_i = VW'(r_src); n_dsrc = '0;
                    n_state = S_CHK;
                end else begin
                    n_v = r_v + VW'(1);
                    n_state = S_IN_RD;
                end
            end
            S_CHK: begin
                if (CW'(r_dsrc) >= n_ext) begin
                    n_state = S_DONE;
                end else begin
                    cur_ra = r_i; dist_ra = r_i;
                    n_state = S_SC_LD;
                end
            end
            S_SC_LD: begin
                n_a = cur_rd; n_di = dist_rd;
                n_state = S_SC_A;
            end
            S_SC_A: begin
                if (r_a >= EMPTY) begin
                    cur_we = 1'b1;
                    n_state = S_RT_A;
                end else begin
                    arc_ra  = r_a[AW-1:0];
                    n_state = S_SC_B;
                end
            end
            S_SC_B: begin
                n_head = arc_rd_head; n_res = arc_rd_res; n_next = arc_rd_next;
                dist_ra = arc_rd_head;
                n_state = S_SC_C;
            end
            S_SC_C: begin
                if (arc_usable && dist_p1 == CW'(r_di)) begin
                    cur_we = 1'b1; cur_wd = r_a;
                    par_we = 1'b1;
                    if (CW'(r_head) == CW'(r_snk)) begin
                        n_nf = '1; n_v = r_head; n_pass = 1'b0;
                        n_state = S_AG_P;
                    end else begin
                        n_i = r_head;
                        n_state = S_CHK;
                    end
                end else begin
                    n_a = r_next;
                    n_state = S_SC_A;
                end
            end
            S_RT_A: begin
                cnt_ra  = r_di;
                n_state = S_RT_B;
            end
            S_RT_B: begin
                cnt_we = 1'b1; cnt_wa = r_di; cnt_wd = cnt_rd - VW'(1);
                // Gap exit: no vertex is left at this label.
                n_state = (cnt_wd == '0) ? S_DONE : S_RL_F;
            end
            S_RL_F: begin
                fa_ra   = r_i;
                n_state = S_RL_F2;
            end
            S_RL_F2: begin
                n_fa = fa_cur; n_a = fa_cur; n_newd = VW'(r_vcount);
                n_state = S_RL_A;
            end
            S_RL_A: begin
                if (r_a >= EMPTY) begin
                    n_state = S_RL_END;
                end else begin
                    arc_ra  = r_a[AW-1:0];
                    n_state = S_RL_B;
                end
            end
            S_RL_B: begin
                n_head = arc_rd_head; n_res = arc_rd_res; n_next = arc_rd_next;
                dist_ra = arc_rd_head;
                n_state = S_RL_C;
            end
            S_RL_C: begin
                if (arc_usable && dist_p1 < CW'(r_newd)) begin
                    n_newd = dist_p1[VW-1:0];
                end
                n_a = r_next;
                n_state = S_RL_A;
            end
            S_RL_END: begin
                dist_we = 1'b1; dist_wa = r_i; dist_wd = r_newd;
                cur_we = 1'b1; cur_wd = r_fa;
                cnt_ra = r_newd;
                if (CW'(r_i) == CW'(r_src)) n_dsrc = r_newd;
                n_state = S_RL_INC;
            end
            S_RL_INC: begin
                cnt_we = 1'b1; cnt_wa = r_newd; cnt_wd = cnt_rd + VW'(1);
                if (CW'(r_i) == CW'(r_src)) begin
                    n_state = S_CHK;
                end else begin
                    par_ra  = r_i;
                    n_state = S_RL_P;
                end
            end
            S_RL_P: begin
                arc_ra  = par_rd;
                n_state = S_RL_T;
            end
            S_RL_T: begin
                n_i = arc_rd_tail;
                n_state = S_CHK;
            end
            S_AG_P: begin
                // First pass finds the bottleneck, second pass pushes it.
                if (CW'(r_v) == CW'(r_src)) begin
                    if (!r_pass) begin
                        n_pass = 1'b1; n_v = VW'(r_snk);
                    end else begin
                        n_total = r_total + FLOW_W'(r_nf);
                        n_i = VW'(r_src);
                        n_state = S_CHK;
                    end
                end else begin
                    par_ra  = r_v;
                    n_state = S_AG_Q;
                end
            end
            S_AG_Q: begin
                n_p = par_rd; arc_ra = par_rd;
                n_state = S_AG_R;
            end
            S_AG_R: begin
                n_v = arc_rd_tail;
                if (!r_pass) begin
                    if (arc_rd_res < r_nf) n_nf = arc_rd_res;
                    n_state = S_AG_P;
                end else begin
                    res_we = 1'b1; res_wa = r_p; res_wd = arc_rd_res - r_nf;
                    arc_ra = {r_p[AW-1:1], ~r_p[0]};
                    n_state = S_AG_S;
                end
            end
            S_AG_S: begin
                res_we = 1'b1; res_wa = {r_p[AW-1:1], ~r_p[0]};
                res_wd = arc_rd_res + r_nf;
                n_state = S_AG_P;
            end
            S_DONE: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_arcs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_k} <= (PW + 1)'(MAX_ARCS))
        else $error("arc count beyond the arc store");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.req_type == REQ_CLEAR) |=> (r_k == '0))
        else $error("clear left arcs in use");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.status == ST_OK || o_rsp.status == ST_FULL
                         || o_rsp.status == ST_RANGE))
        else $error("status code out of range");
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.added_flow == '0))
        else $error("refused request reports flow");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_ov || o_rsp.ready))
        else $error("result overwrote a pending word");

endmodule

// ----- dv/imf_tb_pkg.sv -----
`timescale 1ns / 1ps
// Flow-graph predictor for the incremental max-flow unit testbench.
package imf_tb_pkg;
    import imf_pkg::*;

    localparam int NV = 256;
    localparam int NA = 4096;
    localparam int NO_ARC = NA;

    class flow_graph_model;
        int unsigned tail_of[NA];
        int unsigned head_of[NA];
        int unsigned resid[NA];
        int unsigned next_of[NA];
        int unsigned first_of[NV + 1];
        int unsigned dlabel[NV + 1];
        int unsigned cnt[NV + 1];
        int unsigned cur[NV + 1];
        int unsigned par[NV + 1];
        int unsigned n_arcs;
        int unsigned n_vtx;
        int unsigned src;
        int unsigned snk;

        function new();
            foreach (first_of[v]) first_of[v] = NO_ARC;
            foreach (par[v]) par[v] = 0;
            n_arcs = 0;
            n_vtx = 2;
            src = 1;
            snk = 2;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [VTX_W-1:0] val);
            case (idx)
                CFG_VCOUNT: n_vtx = 32'(val);
                CFG_SOURCE: src = 32'(val);
                CFG_SINK:   snk = 32'(val);
                default: ;
            endcase
        endfunction

        function void link(int unsigned k, int unsigned f, int unsigned t, int unsigned c);
            tail_of[k] = f;
            head_of[k] = t;
            resid[k] = c;
            next_of[k] = first_of[f];
            first_of[f] = k;
        endfunction

        function bit usable(int unsigned a, int unsigned n);
            return resid[a] != 0 && head_of[a] <= n;
        endfunction

        function int unsigned augment(int unsigned n);
            int unsigned total, v, i, a, nf;
            total = 0;
            for (v = 1; v <= n; v++) begin
                dlabel[v] = 0;
                cnt[v] = 0;
                cur[v] = first_of[v];
            end
            cnt[0] = n;
            i = src;
            while (dlabel[src] < n) begin
                a = cur[i];
                while (a < NA && !(usable(a, n) && dlabel[head_of[a]] + 1 == dlabel[i]))
                    a = next_of[a];
                cur[i] = a;
                if (a < NA) begin
                    i = head_of[a];
                    par[i] = a;
                    if (i == snk) begin
                        nf = 32'h7FFF_FFFF;
                        for (v = snk; v != src; v = tail_of[par[v]])
                            if (resid[par[v]] < nf) nf = resid[par[v]];
                        for (v = snk; v != src; v = tail_of[par[v]]) begin
                            resid[par[v]] -= nf;
                            resid[par[v] ^ 1] += nf;
                        end
                        total += nf;
                        i = src;
                    end
                end else begin
                    cnt[dlabel[i]]--;
                    if (cnt[dlabel[i]] == 0) return total;
                    dlabel[i] = n;
                    for (a = first_of[i]; a < NA; a = next_of[a])
                        if (usable(a, n) && dlabel[head_of[a]] + 1 < dlabel[i])
                            dlabel[i] = dlabel[head_of[a]] + 1;
                    cnt[dlabel[i]]++;
                    cur[i] = first_of[i];
                    if (i != src) i = tail_of[par[i]];
                end
            end
            return total;
        endfunction

        // Returns the flow gained and the status of one request.
        function void request(logic rt, int unsigned x, int unsigned y, int unsigned c,
                              output logic [FLOW_W-1:0] flow, output logic [1:0] st);
            int unsigned n, k;
            n = n_vtx;
            flow = '0;
            st = ST_OK;
            if (rt == REQ_CLEAR) begin
                foreach (first_of[v]) first_of[v] = NO_ARC;
                n_arcs = 0;
                return;
            end
            if (n < 2 || n > NV || src < 1 || src > n || snk < 1 || snk > n ||
                src == snk || x < 1 || x > n || y < 1 || y > n) begin
                st = ST_RANGE;
                return;
            end
            if (n_arcs + 4 > NA) begin
                st = ST_FULL;
                return;
            end
            k = n_arcs;
            link(k, x, y, c);
            link(k + 1, y, x, 0);
            link(k + 2, y, x, c);
            link(k + 3, x, y, 0);
            n_arcs = k + 4;
            flow = FLOW_W'(augment(n));
        endfunction
    endclass
endpackage

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top for the incremental max-flow unit: directed table, bad setups, then random phases.
module testbench;
    import imf_pkg::*;
    import imf_tb_pkg::*;

    typedef struct packed {
        logic              rt;
        logic [VTX_W-1:0]  x;
        logic [VTX_W-1:0]  y;
        logic [CAP_W-1:0]  cap;
        logic              fixed;
        logic [FLOW_W-1:0] flow;
        logic [1:0]        st;
    } t_row;

    typedef struct packed {
        logic [FLOW_W-1:0] flow;
        logic [1:0]        st;
    } t_result;

    localparam int WATCHDOG = 4000000;
    // An index past the register list; writes to it are ignored.
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    imf_req_if req_ch();
    imf_rsp_if rsp_ch();
    imf_cfg_if cfg_ch();

    incremental_max_flow_isap_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(req_ch.sink), .o_rsp(rsp_ch.source), .i_cfg(cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    flow_graph_model graph;
    t_result pending_results[$];
    int errors = 0;
    int model_errors = 0;
    int idle_cycles = 0;
    bit stall_on = 1'b0;

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    // Response side: random stalls under stall_on; checks each word against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word flow=%0d status=%0d", $time,
                         rsp_ch.added_flow, rsp_ch.status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.added_flow !== want.flow) begin
                    $display("%0t: added_flow expected %0d actual %0d", $time,
                             want.flow, rsp_ch.added_flow);
                    errors++;
                end
                if (rsp_ch.status !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.st, rsp_ch.status);
                    errors++;
                end
            end
        end
        if (!i_rst_n) rsp_ch.ready <= 1'b0;
        else if (!stall_on) rsp_ch.ready <= 1'b1;
        else rsp_ch.ready <= ($urandom_range(0, 3) == 0) ? 1'b0 :
                             ($urandom_range(0, 1) == 0);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [VTX_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        graph.write_reg(idx, val);
        cfg_ch.valid <= 1'b0;
    endtask

    // Waits for every outstanding word, then a margin for the unit to settle.
    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Valid stays high into the next word unless a gap comes first.
    task automatic send(t_row r);
        int g;
        t_result res;
        g = gap_len();
        if (g != 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= r.rt;
        req_ch.first_vertex <= r.x;
        req_ch.second_vertex <= r.y;
        req_ch.edge_capacity <= r.cap;
        do @(posedge i_clk); while (!req_ch.ready);
        graph.request(r.rt, 32'(r.x), 32'(r.y), 32'(r.cap), res.flow, res.st);
        if (r.fixed && (res.flow !== r.flow || res.st !== r.st)) begin
            $display("%0t: table row expected flow=%0d status=%0d, model %0d/%0d",
                     $time, r.flow, r.st, res.flow, res.st);
            model_errors++;
        end
        pending_results.push_back(res);
    endtask

    function automatic t_row mk(logic rt, int x, int y, int c);
        t_row r;
        r = '0;
        r.rt = rt;
        r.x = VTX_W'(x);
        r.y = VTX_W'(y);
        r.cap = CAP_W'(c);
        return r;
    endfunction

    function automatic t_row mkf(logic rt, int x, int y, int c, int f, logic [1:0] s);
        t_row r;
        r = mk(rt, x, y, c);
        r.fixed = 1'b1;
        r.flow = FLOW_W'(f);
        r.st = s;
        return r;
    endfunction

    task automatic random_phase(int count, int nv);
        int k, x, y;
        for (k = 0; k < count; k++) begin
            x = $urandom_range(1, nv);
            y = $urandom_range(1, nv);
            case ($urandom_range(0, 19))
                0: send(mk(REQ_CLEAR, $urandom, $urandom, $urandom));
                1: send(mk(REQ_ADD, $urandom_range(0, 511), y, $urandom));
                2: send(mk(REQ_ADD, x, y, $urandom_range(0, 1) ? 16'hFFFF : 0));
                default: send(mk(REQ_ADD, x, y, $urandom_range(0, 15) == 0 ?
                                 $urandom : $urandom_range(1, 100)));
            endcase
        end
        req_ch.valid <= 1'b0;
    endtask

    t_row table_rows[$];
    int i;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_CLEAR;
        req_ch.first_vertex = '0;
        req_ch.second_vertex = '0;
        req_ch.edge_capacity = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_VCOUNT;
        cfg_ch.data = '0;
        graph = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default setup: two vertices, source 1, sink 2.
        table_rows.push_back(mkf(REQ_ADD, 1, 2, 16'hFFFF, 65535, ST_OK));
        table_rows.push_back(mkf(REQ_ADD, 2, 1, 5, 5, ST_OK));
        table_rows.push_back(mkf(REQ_ADD, 1, 2, 0, 0, ST_OK));
        table_rows.push_back(mkf(REQ_ADD, 0, 2, 7, 0, ST_RANGE));
        table_rows.push_back(mkf(REQ_ADD, 1, 3, 7, 0, ST_RANGE));
        table_rows.push_back(mkf(REQ_ADD, 511, 511, 7, 0, ST_RANGE));
        table_rows.push_back(mkf(REQ_ADD, 1, 1, 9, 0, ST_OK));
        table_rows.push_back(mkf(REQ_CLEAR, 511, 511, 16'hFFFF, 0, ST_OK));
        table_rows.push_back(mkf(REQ_ADD, 2, 2, 3, 0, ST_OK));
        table_rows.push_back(mkf(REQ_ADD, 1, 2, 1, 1, ST_OK));
        table_rows.push_back(mkf(REQ_CLEAR, 0, 0, 0, 0, ST_OK));
        for (i = 0; i < table_rows.size(); i++) send(table_rows[i]);
        req_ch.valid <= 1'b0;
        drain();

        // Bad setups: source equals sink, vertex count below range, then above range.
        write_reg(CFG_SINK, 1);
        send(mkf(REQ_ADD, 1, 2, 4, 0, ST_RANGE));
        req_ch.valid <= 1'b0;
        drain();
        write_reg(CFG_VCOUNT, 1);
        write_reg(CFG_SINK, 2);
        send(mkf(REQ_ADD, 1, 1, 4, 0, ST_RANGE));
        req_ch.valid <= 1'b0;
        drain();
        write_reg(CFG_VCOUNT, 9'h1FF);
        write_reg(CFG_UNUSED, 9'h0AA);
        send(mkf(REQ_ADD, 1, 2, 4, 0, ST_RANGE));
        req_ch.valid <= 1'b0;
        drain();

        // Small graph, source and sink at its ends.
        stall_on = 1'b1;
        write_reg(CFG_VCOUNT, 6);
        write_reg(CFG_SOURCE, 6);
        write_reg(CFG_SINK, 1);
        send(mk(REQ_CLEAR, 0, 0, 0));
        random_phase(40, 6);
        drain();

        // Shrink the vertex count over a live graph.
        write_reg(CFG_VCOUNT, 4);
        write_reg(CFG_SOURCE, 2);
        write_reg(CFG_SINK, 4);
        random_phase(15, 4);
        drain();

        // Full vertex range with the extreme labels as endpoints.
        stall_on = 1'b0;
        write_reg(CFG_VCOUNT, 256);
        write_reg(CFG_SOURCE, 256);
        write_reg(CFG_SINK, 1);
        send(mk(REQ_CLEAR, 0, 0, 0));
        send(mk(REQ_ADD, 256, 128, 300));
        send(mk(REQ_ADD, 128, 1, 200));
        send(mk(REQ_ADD, 256, 1, 16'hFFFF));
        send(mk(REQ_ADD, 257, 1, 5));
        random_phase(15, 12);
        drain();

        // Parallel edges and self loops on a two-vertex graph.
        write_reg(CFG_VCOUNT, 2);
        write_reg(CFG_SOURCE, 1);
        write_reg(CFG_SINK, 2);
        send(mk(REQ_CLEAR, 0, 0, 0));
        for (i = 0; i < 10; i++)
            send(mk(REQ_ADD, $urandom_range(1, 2), $urandom_range(1, 2),
                    $urandom_range(0, 3)));
        stall_on = 1'b1;
        random_phase(10, 2);
        drain();

        if (errors == 0 && model_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/imf_pkg.sv
hw/rtl/imf_if.sv
hw/rtl/incremental_max_flow_isap_unit.sv
dv/imf_tb_pkg.sv
dv/testbench.sv
